@@ rtl/dvoc_pkg.sv @@
// ----------------------------------------------------------------------------
// dvoc_pkg
// Shared types, constants and helper functions for the distinct value
// occurrence counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dvoc_pkg;

   // Field widths
   localparam int WORD_W      = 32;
   localparam int OCC_W       = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [OCC_W-1:0] OCC_MAX = '1;

   // Request payload
   typedef struct packed {
      logic [WORD_W-1:0] sample_bits;
      logic              set_end;
   } dvoc_req_type;

   // Result payload
   typedef struct packed {
      logic [WORD_W-1:0] unique_bits;
      logic [OCC_W-1:0]  occurrences;
      logic              overflow_flag;
      logic              run_end;
   } dvoc_rsp_type;

   // Classified item held in the front queue
   typedef struct packed {
      logic [WORD_W-1:0] sample;
      logic              last_item;
      logic              nan_flag;
      logic              zero_flag;
   } dvoc_item_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT_RD,
      ST_EMIT_WR
   } dvoc_state_type;

   // Exponent all ones with a non-zero mantissa
   function automatic logic is_nan_word(input logic [WORD_W-1:0] w);
      return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
   endfunction

   // Either signed zero
   function automatic logic is_zero_word(input logic [WORD_W-1:0] w);
      return (w[30:0] == 31'd0);
   endfunction

endpackage

`default_nettype wire

@@ rtl/distinct_value_occurrence_counter_top.sv @@
// Scan: an item taken from the queue is compared against the stored entries until
//   it matches or misses the last entry; a run's results then follow one by one.
// The next item is taken only once the current one resolves, set by the single
//   comparator scanning the table memory one entry per cycle.
// Reset: clears queue, entry count, overflow mark and result valid; the table
//   memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// distinct_value_occurrence_counter_top
// Counts occurrences of distinct single-precision values per run and reports
// each distinct value with its count after the run's last item.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_value_occurrence_counter_top #(
   parameter int TABLE_DEPTH = 64,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire dvoc_pkg::dvoc_req_type req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output dvoc_pkg::dvoc_rsp_type      rsp_payload
);
   import dvoc_pkg::*;

   logic          q_valid;
   logic          q_pop;
   dvoc_item_type q_item;

   // Front: accept and classify
   dvoc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   // Back: table scan, update and read-out
   dvoc_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef NO_ASSERTIONS
   // Every reported value was seen at least once
   a_occ_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.occurrences != '0))
      else $error("zero occurrence count reported");

   // A full queue always has an item to offer
   a_full_nonempty: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("queue full but empty to the back end");

   // A waiting result stays valid with its payload unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("waiting result dropped or changed");
`endif

endmodule

`default_nettype wire

@@ rtl/dvoc_front.sv @@
// ----------------------------------------------------------------------------
// dvoc_front
// Input side: accepts items, tags NaN and zero words, and holds them in a
// short queue until the back end is free to take them.
// ----------------------------------------------------------------------------
`default_nettype none

module dvoc_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire dvoc_pkg::dvoc_req_type req_payload,
   output logic                        q_valid,
   output dvoc_pkg::dvoc_item_type     q_item,
   input  wire logic                   q_pop
);
   import dvoc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

   dvoc_item_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   dvoc_item_type    new_item;
   logic             push;
   logic             pop;

   // Classify the incoming word
   always_comb begin
      new_item.sample    = req_payload.sample_bits;
      new_item.last_item = req_payload.set_end;
      new_item.nan_flag  = is_nan_word(req_payload.sample_bits);
      new_item.zero_flag = is_zero_word(req_payload.sample_bits);
   end

   assign req_ready = (level_ff != LVL_W'(QUEUE_DEPTH));
   assign q_valid   = (level_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + LVL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

@@ rtl/dvoc_back.sv @@
// ----------------------------------------------------------------------------
// dvoc_back
// Table engine: scans the stored values one entry a cycle with a single
// comparator, bumps, appends or marks overflow, and on a run's last item
// reads the table out through the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dvoc_back #(
   parameter int TABLE_DEPTH = 64,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   input  wire dvoc_pkg::dvoc_item_type q_item,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output dvoc_pkg::dvoc_rsp_type       rsp_payload
);
   import dvoc_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int ENT_W = WORD_W + COUNT_WIDTH;

   // Table memory: value in the upper bits, count in the lower
   logic [ENT_W-1:0]       table_mem [TABLE_DEPTH];
   logic [ENT_W-1:0]       rd_data_ff;

   dvoc_state_type         state_ff, state_in;
   logic [CNT_W-1:0]       entry_count_ff, entry_count_in;
   logic                   overflow_ff, overflow_in;
   dvoc_item_type          cur_ff, cur_in;
   logic [CNT_W-1:0]       issue_idx_ff, issue_idx_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]       emit_idx_ff, emit_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   dvoc_rsp_type           rsp_payload_ff, rsp_payload_in;

   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ENT_W-1:0]       wr_data;

   logic [WORD_W-1:0]      stored_word;
   logic [COUNT_WIDTH-1:0] stored_cnt;
   logic [COUNT_WIDTH-1:0] bumped_cnt;
   logic [31:0]            cnt_wide;
   logic [OCC_W-1:0]       occ_clip;
   logic                   hit;
   logic                   pend_last;
   logic                   miss;
   logic                   resolve;
   logic                   room;
   logic                   emit_last;
   logic                   rsp_free;

   // Compare the entry read last cycle against the current item
   always_comb begin
      stored_word = rd_data_ff[ENT_W-1 -: WORD_W];
      stored_cnt  = rd_data_ff[COUNT_WIDTH-1:0];
      bumped_cnt  = (stored_cnt == {COUNT_WIDTH{1'b1}}) ? stored_cnt
                                                         : stored_cnt + COUNT_WIDTH'(1);
      cnt_wide    = 32'(stored_cnt);
      occ_clip    = (cnt_wide > 32'(OCC_MAX)) ? OCC_MAX : cnt_wide[OCC_W-1:0];
      hit         = pend_ff && !cur_ff.nan_flag && !is_nan_word(stored_word) &&
                    ((cur_ff.zero_flag && is_zero_word(stored_word)) ||
                     (cur_ff.sample == stored_word));
      pend_last   = (CNT_W'(pend_idx_ff) + CNT_W'(1)) == entry_count_ff;
      miss        = (entry_count_ff == '0) || (pend_ff && !hit && pend_last);
      resolve     = (state_ff == ST_SCAN) && (hit || miss);
      room        = entry_count_ff < CNT_W'(TABLE_DEPTH);
      emit_last   = (CNT_W'(emit_idx_ff) + CNT_W'(1)) == entry_count_ff;
      rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (resolve) begin
               state_in = cur_ff.last_item ? ST_EMIT_RD : ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (rsp_free) begin
               state_in = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath controls and register next values
   always_comb begin
      q_pop          = 1'b0;
      cur_in         = cur_ff;
      issue_idx_in   = issue_idx_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      emit_idx_in    = emit_idx_ff;
      entry_count_in = entry_count_ff;
      overflow_in    = overflow_ff;
      rd_en          = 1'b0;
      rd_addr        = issue_idx_ff[IDX_W-1:0];
      wr_en          = 1'b0;
      wr_addr        = pend_idx_ff;
      wr_data        = {stored_word, bumped_cnt};
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      case (state_ff)
         ST_IDLE: begin
            q_pop        = q_valid;
            issue_idx_in = '0;
            if (q_valid) begin
               cur_in = q_item;
            end
         end
         ST_SCAN: begin
            // keep one read in flight ahead of the compare
            if (!resolve && (issue_idx_ff < entry_count_ff)) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_idx_in  = issue_idx_ff[IDX_W-1:0];
               issue_idx_in = issue_idx_ff + CNT_W'(1);
            end
            if (hit) begin
               wr_en = 1'b1;
            end else if (miss) begin
               if (room) begin
                  wr_en          = 1'b1;
                  wr_addr        = entry_count_ff[IDX_W-1:0];
                  wr_data        = {cur_ff.sample, COUNT_WIDTH'(1)};
                  entry_count_in = entry_count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
         end
         ST_EMIT_RD: begin
            rd_en   = 1'b1;
            rd_addr = emit_idx_ff;
         end
         ST_EMIT_WR: begin
            if (rsp_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.unique_bits   = stored_word;
               rsp_payload_in.occurrences   = occ_clip;
               rsp_payload_in.overflow_flag = overflow_ff;
               rsp_payload_in.run_end       = emit_last;
               if (emit_last) begin
                  emit_idx_in    = '0;
                  entry_count_in = '0;
                  overflow_in    = 1'b0;
               end else begin
                  emit_idx_in = emit_idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         overflow_ff    <= 1'b0;
         issue_idx_ff   <= '0;
         pend_ff        <= 1'b0;
         emit_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         overflow_ff    <= overflow_in;
         issue_idx_ff   <= issue_idx_in;
         pend_ff        <= pend_in;
         emit_idx_ff    <= emit_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      pend_idx_ff    <= pend_idx_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Table memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire
